@@ rtl/rhsv_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
package rhsv_pkg;

	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned SAT_REM_W  = CHAN_W + 1;
	localparam int unsigned HUE_DIV_W  = CHAN_W + 3;
	localparam int unsigned HUE_REM_W  = HUE_DIV_W + 1;
	localparam int unsigned NUM_CELLS  = FRAC_W;
	// front stage + one stage per cell + output stage
	localparam int unsigned PIPE_DEPTH = NUM_CELLS + 2;
	localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FRAC_W-1:0] hue;
		logic [FRAC_W-1:0] saturation;
		logic [CHAN_W-1:0] brightness;
	} hsv_t;

	// Data handed from cell to cell: two restoring divisions side by side.
	typedef struct packed {
		logic [SAT_REM_W-1:0] sat_rem;
		logic [CHAN_W-1:0]    sat_div;
		logic [FRAC_W-1:0]    sat_quo;
		logic [HUE_REM_W-1:0] hue_rem;
		logic [HUE_DIV_W-1:0] hue_div;
		logic [FRAC_W-1:0]    hue_quo;
		logic                 gray;
		logic                 sat_full;
		logic [CHAN_W-1:0]    brightness;
	} cell_t;

endpackage

@@ rtl/rgb_to_hsv_converter_core.sv @@
// RGB to HSV converter: top level with the front stage and the division cell chain.
//
// Usage:
//   Present a pixel on 'pixel' and raise 'start'. The beat is taken at any rising
//   edge where start is high and busy is low. busy is always low here, so a new
//   pixel may be sent on every clock.
//   The result beat appears on 'result' with 'done' high for exactly one cycle,
//   after passing through one front stage (max, min, delta, hue numerator),
//   sixteen division cells each retiring one quotient bit of hue and of
//   saturation, and one output register that applies the gray and
//   full-saturation cases.
//   Throughput is one pixel per clock; the cell chain is fully pipelined and
//   holds up to eighteen pixels in flight. Results leave in input order.
//   The receiver cannot stall: every result is shown once, for one cycle.
//   Reset (arst_n low) clears all valid flags at once; pixels in flight are
//   dropped and no result follows them. Data registers are not reset.
module rgb_to_hsv_converter_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rhsv_pkg::pixel_t pixel,
	output logic             done,
	output rhsv_pkg::hsv_t   result
);
	import rhsv_pkg::*;

	logic            vld_c [0:NUM_CELLS];
	rhsv_pkg::cell_t cell_c [0:NUM_CELLS];
	rhsv_pkg::hsv_t  res_nxt;

	// Never hold off the sender: the chain advances every cycle.
	assign busy = 1'b0;

	rhsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start),
		.pixel   (pixel),
		.vld_s1  (vld_c[0]),
		.cell_s1 (cell_c[0])
	);

	// Chain of cells: each advances both divisions by one bit.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		rhsv_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (vld_c[i]),
			.d      (cell_c[i]),
			.vld_q  (vld_c[i+1]),
			.cell_q (cell_c[i+1])
		);
	end

	// Gray pixels drop hue and saturation to zero; min of zero means a full
	// quotient, which clamps to the largest fraction.
	always_comb begin
		res_nxt.brightness = cell_c[NUM_CELLS].brightness;
		if (cell_c[NUM_CELLS].gray) begin
			res_nxt.hue        = '0;
			res_nxt.saturation = '0;
		end else begin
			res_nxt.hue        = cell_c[NUM_CELLS].hue_quo;
			res_nxt.saturation = cell_c[NUM_CELLS].sat_full ? FRAC_MAX
			                                                : cell_c[NUM_CELLS].sat_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_c[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		result <= res_nxt;
	end

endmodule

@@ rtl/rhsv_front.sv @@
// Front stage: max, min, delta, hue sector numerator and divisors.
module rhsv_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  rhsv_pkg::pixel_t pixel,
	output logic            vld_s1,
	output rhsv_pkg::cell_t  cell_s1
);
	import rhsv_pkg::*;

	logic [CHAN_W-1:0]    mx, mn, delta;
	logic [HUE_REM_W-1:0] d_w, six_d, num;
	rhsv_pkg::cell_t      nxt;

	always_comb begin
		mx = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx) mx = pixel.blue;
		mn = pixel.red;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
		delta = mx - mn;
		d_w   = HUE_REM_W'(delta);
		six_d = (d_w << 2) + (d_w << 1);

		// Sector priority red, green, blue; sums wrap but the result is in range.
		priority if (pixel.red == mx) begin
			num = HUE_REM_W'(pixel.green) - HUE_REM_W'(pixel.blue);
			if (pixel.green < pixel.blue) num = num + six_d;
		end else if (pixel.green == mx) begin
			num = (d_w << 1) + HUE_REM_W'(pixel.blue) - HUE_REM_W'(pixel.red);
		end else begin
			num = (d_w << 2) + HUE_REM_W'(pixel.red) - HUE_REM_W'(pixel.green);
		end

		nxt.sat_rem    = SAT_REM_W'(delta);
		nxt.sat_div    = mx;
		nxt.sat_quo    = '0;
		nxt.hue_rem    = num;
		nxt.hue_div    = HUE_DIV_W'(six_d);
		nxt.hue_quo    = '0;
		nxt.gray       = (delta == '0);
		nxt.sat_full   = (mn == '0);
		nxt.brightness = mx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		cell_s1 <= nxt;
	end

endmodule

@@ rtl/rhsv_cell.sv @@
// One division cell: retires one quotient bit of hue and of saturation.
module rhsv_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld,
	input  rhsv_pkg::cell_t d,
	output logic           vld_q,
	output rhsv_pkg::cell_t cell_q
);
	import rhsv_pkg::*;

	logic [SAT_REM_W-1:0] sat_t;
	logic [HUE_REM_W-1:0] hue_t;
	logic                 sat_bit, hue_bit;
	rhsv_pkg::cell_t      nxt;

	always_comb begin
		nxt     = d;
		sat_t   = d.sat_rem << 1;
		hue_t   = d.hue_rem << 1;
		sat_bit = (sat_t >= SAT_REM_W'(d.sat_div));
		hue_bit = (hue_t >= HUE_REM_W'(d.hue_div));
		nxt.sat_rem = sat_bit ? sat_t - SAT_REM_W'(d.sat_div) : sat_t;
		nxt.hue_rem = hue_bit ? hue_t - HUE_REM_W'(d.hue_div) : hue_t;
		nxt.sat_quo = {d.sat_quo[FRAC_W-2:0], sat_bit};
		nxt.hue_quo = {d.hue_quo[FRAC_W-2:0], hue_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= nxt;
	end

endmodule

@@ rtl/rhsv_checker.sv @@
// Port-level checker for the RGB to HSV converter, bound to the top level.
module rhsv_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input rhsv_pkg::hsv_t   result
);
	import rhsv_pkg::*;

	localparam int unsigned LAT = PIPE_DEPTH;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result beat missing after accepted pixel");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without matching pixel");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.brightness == '0) |-> (result.hue == '0 && result.saturation == '0))
		else $error("black pixel with nonzero hue or saturation");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturation == '0) |-> (result.hue == '0))
		else $error("unsaturated pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_core rhsv_checker u_rhsv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
